// ===== hw/rtl/ccu_pkg.sv =====
// Shared types and constants for the combinatorial count unit.
package ccu_pkg;

   localparam int WIDTH     = 64;
   localparam int CNT_W     = 9;
   localparam int PROD_W    = WIDTH + CNT_W;
   localparam int DIV_CNT_W = $clog2(WIDTH + 1);

   typedef enum logic [1:0] {
      OP_FACT    = 2'd0,
      OP_PERM    = 2'd1,
      OP_COMB    = 2'd2,
      OP_CATALAN = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FACT_INIT,
      ST_FACT_RUN,
      ST_DIV_RUN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       fact_init;
      logic       fact_step;
      logic [1:0] fact_sel;
      logic       div_init;
      logic       div_sel;
      logic       div_step;
      logic       emit;
      logic       emit_ovf;
   } ccu_cmd_type;

   typedef struct packed {
      op_type op;
      logic   fact_done;
      logic   mul_ovf;
      logic   div_done;
   } ccu_status_type;

endpackage

// ===== hw/rtl/ccu_ctrl.sv =====
// Sequencer for the factorial and division phases of one transaction.
module ccu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output ccu_pkg::ccu_cmd_type    cmd,
   input  ccu_pkg::ccu_status_type st
);
   import ccu_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       dphase_ff, dphase_in;
   logic [1:0] last_fact;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= 2'd0;
         dphase_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         dphase_ff <= dphase_in;
      end
   end

   always_comb begin
      case (st.op)
         OP_FACT: last_fact = 2'd0;
         OP_PERM: last_fact = 2'd1;
         default: last_fact = 2'd2;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      dphase_in    = dphase_ff;
      busy         = 1'b1;
      cmd          = '0;
      cmd.fact_sel = phase_ff;
      cmd.div_sel  = dphase_ff;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               phase_in = 2'd0;
               state_in = ST_FACT_INIT;
            end
         end
         ST_FACT_INIT: begin
            cmd.fact_init = 1'b1;
            state_in      = ST_FACT_RUN;
         end
         ST_FACT_RUN: begin
            if (st.fact_done) begin
               if (phase_ff != last_fact) begin
                  phase_in = phase_ff + 2'd1;
                  state_in = ST_FACT_INIT;
               end else if (st.op == OP_FACT) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.div_init = 1'b1;
                  dphase_in    = 1'b0;
                  state_in     = ST_DIV_RUN;
               end
            end else if (st.mul_ovf) begin
               // abandon the transaction: a needed factorial does not fit
               cmd.emit     = 1'b1;
               cmd.emit_ovf = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.fact_step = 1'b1;
            end
         end
         ST_DIV_RUN: begin
            if (st.div_done) begin
               if (dphase_ff || st.op == OP_PERM) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  // divide the quotient again, now by the third factorial
                  cmd.div_init = 1'b1;
                  dphase_in    = 1'b1;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ccu_datapath.sv =====
// Factorial registers, shared multiplier with overflow check, restoring divider.
module ccu_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_n,
   input  logic [7:0]                  req_k,
   input  ccu_pkg::ccu_cmd_type        cmd,
   output ccu_pkg::ccu_status_type     st,
   output logic                        rsp_valid,
   output logic [ccu_pkg::WIDTH-1:0]   rsp_value,
   output logic                        rsp_overflow
);
   import ccu_pkg::*;

   op_type               op_ff, op_in;
   logic [7:0]           n_ff, n_in;
   logic [7:0]           k_ff, k_in;
   logic [WIDTH-1:0]     a_ff, a_in;
   logic [WIDTH-1:0]     b_ff, b_in;
   logic [WIDTH-1:0]     c_ff, c_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WIDTH-1:0]     r_ff, r_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                 valid_ff;
   logic [WIDTH-1:0]     value_ff, value_in;
   logic                 ovf_ff;

   logic [7:0]           nk;
   logic [CNT_W-1:0]     arg;
   logic [WIDTH-1:0]     cur;
   logic [PROD_W-1:0]    prod;
   logic [WIDTH-1:0]     divisor;
   logic [WIDTH:0]       r_sh;
   logic                 ge;
   logic [WIDTH:0]       diff;

   assign nk = (k_ff <= n_ff) ? (n_ff - k_ff) : 8'd0;

   // factorial argument for each phase of the current operation
   always_comb begin
      case (cmd.fact_sel)
         2'd0: begin
            if (op_ff == OP_CATALAN) arg = {n_ff, 1'b0};
            else                     arg = {1'b0, n_ff};
         end
         2'd1: begin
            case (op_ff)
               OP_PERM: arg = {1'b0, nk};
               OP_COMB: arg = {1'b0, k_ff};
               default: arg = {1'b0, n_ff};
            endcase
         end
         default: begin
            if (op_ff == OP_COMB) arg = {1'b0, nk};
            else                  arg = {1'b0, n_ff} + CNT_W'(1);
         end
      endcase
   end

   always_comb begin
      case (cmd.fact_sel)
         2'd1:    cur = b_ff;
         2'd2:    cur = c_ff;
         default: cur = a_ff;
      endcase
   end

   assign prod    = PROD_W'(cur) * PROD_W'(cnt_ff);
   assign divisor = cmd.div_sel ? c_ff : b_ff;
   assign r_sh    = {r_ff, a_ff[WIDTH-1]};
   assign ge      = (r_sh >= {1'b0, divisor});
   assign diff    = r_sh - {1'b0, divisor};

   assign st.op        = op_ff;
   assign st.fact_done = (cnt_ff > arg);
   assign st.mul_ovf   = |prod[PROD_W-1:WIDTH];
   assign st.div_done  = (dcnt_ff == DIV_CNT_W'(WIDTH));

   always_comb begin
      op_in    = op_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      dcnt_in  = dcnt_ff;
      value_in = value_ff;
      if (cmd.load) begin
         op_in = op_type'(req_op);
         n_in  = req_n;
         k_in  = req_k;
      end
      if (cmd.fact_init) begin
         cnt_in = CNT_W'(2);
         case (cmd.fact_sel)
            2'd1:    b_in = WIDTH'(1);
            2'd2:    c_in = WIDTH'(1);
            default: a_in = WIDTH'(1);
         endcase
      end
      if (cmd.fact_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
         case (cmd.fact_sel)
            2'd1:    b_in = prod[WIDTH-1:0];
            2'd2:    c_in = prod[WIDTH-1:0];
            default: a_in = prod[WIDTH-1:0];
         endcase
      end
      if (cmd.div_init) begin
         r_in    = '0;
         dcnt_in = '0;
      end
      if (cmd.div_step) begin
         // shift the dividend out and the quotient bit in
         r_in    = ge ? diff[WIDTH-1:0] : r_sh[WIDTH-1:0];
         a_in    = {a_ff[WIDTH-2:0], ge};
         dcnt_in = dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.emit) begin
         value_in = cmd.emit_ovf ? '0 : a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      cnt_ff   <= cnt_in;
      r_ff     <= r_in;
      dcnt_ff  <= dcnt_in;
      value_ff <= value_in;
      if (cmd.emit) begin
         ovf_ff <= cmd.emit_ovf;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

endmodule

// ===== hw/rtl/combinatorial_count_unit_top.sv =====
// Top level of the combinatorial count unit.
// A transaction is taken when start is high and busy is low; it returns n!, A(n,k),
// C(n,k) or the Catalan number of n as one result strobed on rsp_valid for a single
// cycle, which the receiver cannot stall. Each needed factorial is built on one
// shared 64x9 multiplier, one factor per cycle (at most 20!, since a product past
// 64 bits ends the transaction with overflow set and a zero value); each division
// is a restoring divider at one quotient bit per cycle. An overflow result returns
// as soon as a product overflows, without the remaining phases.
module combinatorial_count_unit_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_op,
   input  logic [7:0]                req_n,
   input  logic [7:0]                req_k,
   output logic                      rsp_valid,
   output logic [ccu_pkg::WIDTH-1:0] rsp_value,
   output logic                      rsp_overflow
);
   import ccu_pkg::*;

   ccu_cmd_type    cmd;
   ccu_status_type st;
   logic           ctrl_busy;

   ccu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (ctrl_busy),
      .cmd   (cmd),
      .st    (st)
   );

   ccu_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_op),
      .req_n        (req_n),
      .req_k        (req_k),
      .cmd          (cmd),
      .st           (st),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

   assign busy = ctrl_busy;

endmodule

// ===== hw/rtl/ccu_checker.sv =====
// Port-level checks for the combinatorial count unit, bound to the top level.
module ccu_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [1:0]                req_op,
   input logic [7:0]                req_n,
   input logic [7:0]                req_k,
   input logic                      rsp_valid,
   input logic [ccu_pkg::WIDTH-1:0] rsp_value,
   input logic                      rsp_overflow
);

   // an accepted transaction keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // a result only comes out of a running transaction
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a running transaction");

   // release of busy delivers the result
   a_fell_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // the result strobe is never asserted back to back
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_value == '0))
      else $error("overflow result carries a nonzero value");

endmodule

bind combinatorial_count_unit_top ccu_checker u_ccu_checker (.*);
